// ===== rtl/kf2_pkg.sv =====
// shared constants, types and fixed-point helpers for the two-axis kalman filter
// no dependencies
`timescale 1ns / 1ps

package kf2_pkg;

    localparam int FRAC_BITS = 16;
    // numerator of the gain division: |n| << FRAC_BITS plus half the denominator
    localparam int NUM_W = 32 + FRAC_BITS + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);

    localparam logic signed [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

    localparam logic [30:0] RST_PNOISE   = 31'd655;
    localparam logic [30:0] RST_MNOISE   = 31'd6554;
    localparam logic [30:0] RST_GRAVITY  = 31'd642690;
    localparam logic [11:0] RST_THR_IDLE = 12'd1100;
    localparam logic [30:0] RST_REST_ST  = 31'd655360;
    localparam logic [30:0] RST_REST_END = 31'd1310720;

    localparam logic signed [65:0] MAX66 = 66'sd2147483647;
    localparam logic signed [65:0] MIN66 = -66'sd2147483648;

    typedef enum logic [2:0] {
        CFG_PNOISE   = 3'd0,
        CFG_MNOISE   = 3'd1,
        CFG_GRAVITY  = 3'd2,
        CFG_THR_IDLE = 3'd3,
        CFG_REST_ST  = 3'd4,
        CFG_REST_END = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_X1DT  = 4'd0,
        OP_ACCH  = 4'd1,
        OP_ACCDT = 4'd2,
        OP_P3DT  = 4'd3,
        OP_P2DT  = 4'd4,
        OP_PP1DT = 4'd5,
        OP_K0E   = 4'd6,
        OP_K1E   = 4'd7,
        OP_K0P0  = 4'd8,
        OP_K0P1  = 4'd9,
        OP_K1P0  = 4'd10,
        OP_K1P1  = 4'd11
    } t_op;

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL,
        L_USE,
        L_DIVA,
        L_WAITA,
        L_DIVB,
        L_WAITB,
        L_DONE
    } t_lane_st;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] val;
    } t_sat;

    typedef struct packed {
        logic               start;
        logic               zero_vel;
        logic               fix;
        logic        [15:0] dt;
        logic        [15:0] hdt2;
        logic signed [31:0] acc;
        logic signed [31:0] meas;
    } t_lane_cmd;

    typedef struct packed {
        logic               done;
        logic               sat;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
    } t_lane_res;

    function automatic t_sat f_sat(input logic signed [65:0] v);
        t_sat r;
        r.hit = 1'b0;
        r.val = v[31:0];
        if (v > MAX66) begin
            r.hit = 1'b1;
            r.val = 32'sh7FFF_FFFF;
        end else if (v < MIN66) begin
            r.hit = 1'b1;
            r.val = 32'sh8000_0000;
        end
        return r;
    endfunction

    // round to nearest, ties toward plus infinity
    function automatic logic signed [65:0] f_rnd(input logic signed [65:0] p,
                                                 input logic is_t);
        logic signed [65:0] h16;
        logic signed [65:0] hf;
        h16 = p + 66'sd32768;
        hf  = p + (66'sd1 <<< (FRAC_BITS - 1));
        return is_t ? (h16 >>> 16) : (hf >>> FRAC_BITS);
    endfunction

endpackage

// ===== rtl/kf2_in_if.sv =====
// input channel of the kalman filter: valid, ready and one step's payload
// no dependencies
`timescale 1ns / 1ps

interface kf2_in_if;
    logic               valid;
    logic               ready;
    logic        [15:0] step_time;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic        [11:0] throttle;
    logic               new_fix;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_z;

    modport source (output valid, step_time, accel_y, accel_z, throttle, new_fix,
                    meas_y, meas_z, input ready);
    modport sink (input valid, step_time, accel_y, accel_z, throttle, new_fix,
                  meas_y, meas_z, output ready);
endinterface

// ===== rtl/kf2_out_if.sv =====
// result channel of the kalman filter: valid, ready and the state estimate
// no dependencies
`timescale 1ns / 1ps

interface kf2_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_z;
    logic               vel_zeroed;
    logic               saturated;

    modport source (output valid, pos_y, vel_y, pos_z, vel_z, vel_zeroed, saturated,
                    input ready);
    modport sink (input valid, pos_y, vel_y, pos_z, vel_z, vel_zeroed, saturated,
                  output ready);
endinterface

// ===== rtl/pos_vel_kalman_two_axis.sv =====
// without a fix each lane runs its six prediction products; with a fix it also runs
// two bit-serial gain divisions and six correction products
// one step at a time: the next transfer is taken only once the result is registered,
// and the merge waits while the previous result is still held and not taken
// reset: synchronous active low, clears config to defaults, estimates to zero,
// covariances to identity, rest timer and flags to zero
// depends on kf2_pkg, kf2_in_if, kf2_out_if, kf2_lane
`timescale 1ns / 1ps

module pos_vel_kalman_two_axis
    import kf2_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    kf2_in_if.sink      i_item,
    kf2_out_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    // configuration registers
    logic [30:0] r_pnoise, r_mnoise, r_gravity, r_rest_st, r_rest_end;
    logic [11:0] r_thr_idle;

    // step control and rest logic
    logic        r_busy;
    logic        r_start;
    logic        r_zero;
    logic [31:0] r_timer;
    logic        r_sat0;

    // per-step operands held for both lanes
    logic        [15:0] r_dt;
    logic        [15:0] r_hdt2;
    logic signed [31:0] r_ay, r_az, r_my, r_mz;
    logic               r_fix;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_pos_y, r_vel_y, r_pos_z, r_vel_z;
    logic               r_vel_zeroed, r_out_sat;

    logic               accept;
    logic               merge;
    logic [FRAC_BITS-1:0] dtq;
    logic [16+FRAC_BITS-1:0] dt_wide;
    logic [32:0]        tsum;
    logic [31:0]        tsat;
    logic               n_zero;
    logic [31:0]        n_timer;
    logic [31:0]        dtsq;
    t_sat               az1, az2;
    t_lane_cmd          cmd_y, cmd_z;
    t_lane_res          res_y, res_z;

    assign accept       = i_item.valid && i_item.ready;
    assign i_item.ready = !r_busy;
    // merge only once both lanes finished and the output register is free
    assign merge = r_busy && res_y.done && res_z.done && (!r_out_valid || o_res.ready);

    // rest timer: step time in seconds, converted to the fixed-point format
    always_comb begin
        dt_wide = {i_item.step_time, {FRAC_BITS{1'b0}}};
        dtq     = dt_wide[16+FRAC_BITS-1:16];
        tsum    = {1'b0, r_timer} + 33'(dtq);
        tsat    = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
        n_zero  = r_zero;
        n_timer = r_timer;
        if (i_item.throttle > r_thr_idle) begin
            n_zero  = 1'b0;
            n_timer = '0;
        end else begin
            if (r_timer > {1'b0, r_rest_st}) n_zero = 1'b1;
            n_timer = tsat;
            if (tsat > {1'b0, r_rest_end}) begin
                n_timer = '0;
                n_zero  = 1'b0;
            end
        end
    end

    // z acceleration: gravity added, then negated; half dt squared for the position term
    always_comb begin
        az1  = f_sat(66'(i_item.accel_z) + 66'($signed({1'b0, r_gravity})));
        az2  = f_sat(-66'(az1.val));
        dtsq = i_item.step_time * i_item.step_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pnoise   <= RST_PNOISE;
            r_mnoise   <= RST_MNOISE;
            r_gravity  <= RST_GRAVITY;
            r_thr_idle <= RST_THR_IDLE;
            r_rest_st  <= RST_REST_ST;
            r_rest_end <= RST_REST_END;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PNOISE:   r_pnoise   <= i_cfg_data;
                CFG_MNOISE:   r_mnoise   <= i_cfg_data;
                CFG_GRAVITY:  r_gravity  <= i_cfg_data;
                CFG_THR_IDLE: r_thr_idle <= i_cfg_data[11:0];
                CFG_REST_ST:  r_rest_st  <= i_cfg_data;
                CFG_REST_END: r_rest_end <= i_cfg_data;
                default:      r_pnoise   <= r_pnoise; // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_zero      <= 1'b0;
            r_timer     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= accept;
            if (accept) begin
                r_busy  <= 1'b1;
                r_zero  <= n_zero;
                r_timer <= n_timer;
                r_sat0  <= az1.hit | az2.hit;
                r_dt    <= i_item.step_time;
                r_hdt2  <= 16'((33'(dtsq) + 33'h1_0000) >> 17);
                r_ay    <= i_item.accel_y;
                r_az    <= az2.val;
                r_my    <= i_item.meas_y;
                r_mz    <= i_item.meas_z;
                r_fix   <= i_item.new_fix;
            end
            if (merge) begin
                r_busy       <= 1'b0;
                r_out_valid  <= 1'b1;
                r_pos_y      <= res_y.pos;
                r_vel_y      <= res_y.vel;
                r_pos_z      <= res_z.pos;
                r_vel_z      <= res_z.vel;
                r_vel_zeroed <= r_zero;
                r_out_sat    <= r_sat0 | res_y.sat | res_z.sat;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // both lanes share the step operands and the fix, each with its own acceleration and measurement
    always_comb begin
        cmd_y.start    = r_start;
        cmd_y.zero_vel = r_zero;
        cmd_y.fix      = r_fix;
        cmd_y.dt       = r_dt;
        cmd_y.hdt2     = r_hdt2;
        cmd_y.acc      = r_ay;
        cmd_y.meas     = r_my;
        cmd_z          = cmd_y;
        cmd_z.acc      = r_az;
        cmd_z.meas     = r_mz;
    end

    kf2_lane u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_y),
        .i_qn    (r_pnoise),
        .i_r     (r_mnoise),
        .i_ack   (merge),
        .o_res   (res_y)
    );

    kf2_lane u_lane_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_z),
        .i_qn    (r_pnoise),
        .i_r     (r_mnoise),
        .i_ack   (merge),
        .o_res   (res_z)
    );

    assign o_res.valid      = r_out_valid;
    assign o_res.pos_y      = r_pos_y;
    assign o_res.vel_y      = r_vel_y;
    assign o_res.pos_z      = r_pos_z;
    assign o_res.vel_z      = r_vel_z;
    assign o_res.vel_zeroed = r_vel_zeroed;
    assign o_res.saturated  = r_out_sat;

`ifndef SYNTH
    // a new result only ever comes out of a step in progress
    a_result_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy))
        else $error("result appeared without a step in progress");

    // neither lane reports done while no step is in progress
    a_lanes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (!res_y.done && !res_z.done))
        else $error("lane reports done while no step is running");

    // the end of a step always leaves a result waiting
    a_step_ends_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_out_valid)
        else $error("step finished without a result");
`endif

endmodule

// ===== rtl/kf2_div.sv =====
// bit-serial restoring divider for the kalman gain, rounds to nearest
// depends on kf2_pkg
`timescale 1ns / 1ps

module kf2_div
    import kf2_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic        [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_q,
    output logic               o_sat
);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [31:0]          r_rem;
    logic [NUM_W-1:0]     r_num;
    logic [NUM_W-1:0]     r_q;
    logic [31:0]          r_den;
    logic                 r_neg;
    logic                 r_done;
    logic signed [31:0]   r_res;
    logic                 r_sat;

    logic [31:0]          mag;
    logic [32:0]          trial;
    logic                 ge;

    always_comb begin
        mag   = i_num[31] ? (~i_num + 32'd1) : i_num;
        trial = {r_rem, r_num[NUM_W-1]};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= '0;
                r_den  <= i_den;
                r_neg  <= i_num[31];
                r_num  <= NUM_W'({mag, {FRAC_BITS{1'b0}}}) + NUM_W'(i_den >> 1);
            end else if (r_busy && r_cnt != CNT_W'(NUM_W)) begin
                r_rem <= ge ? 32'(trial - {1'b0, r_den}) : trial[31:0];
                r_num <= r_num << 1;
                r_q   <= {r_q[NUM_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
                if (!r_neg && r_q > NUM_W'(32'h7FFF_FFFF)) begin
                    r_res <= 32'sh7FFF_FFFF;
                    r_sat <= 1'b1;
                end else if (r_neg && r_q > NUM_W'(32'h8000_0000)) begin
                    r_res <= 32'sh8000_0000;
                    r_sat <= 1'b1;
                end else begin
                    r_res <= r_neg ? (~r_q[31:0] + 32'd1) : r_q[31:0];
                    r_sat <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_res;
    assign o_sat  = r_sat;

endmodule

// ===== rtl/kf2_lane.sv =====
// one axis of the filter: state, covariance, a shared multiplier and the gain divider
// depends on kf2_pkg and kf2_div
`timescale 1ns / 1ps

module kf2_lane
    import kf2_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_lane_cmd   i_cmd,
    input  logic [30:0] i_qn,
    input  logic [30:0] i_r,
    input  logic        i_ack,
    output t_lane_res   o_res
);

    t_lane_st r_st, n_st;
    t_op      r_op;

    logic signed [31:0] r_x0, r_x1, r_p0, r_p1, r_p2, r_p3;
    logic signed [31:0] r_xp0, r_xp1, r_pp0, r_pp1, r_pp2, r_pp3;
    logic signed [31:0] r_a, r_k0, r_k1, r_e;
    logic signed [65:0] r_prod;
    logic               r_is_t;
    logic               r_sat;

    logic signed [31:0] opa;
    logic signed [32:0] opb;
    logic               is_t;
    t_sat               mres;
    logic signed [31:0] v;
    logic signed [65:0] qn66;
    logic signed [33:0] den;
    logic               den_pos;
    t_sat               s_xp0, s_xp1, s_pp1, s_pp2, s_pp3, s_pp0, s_e;
    t_sat               s_c0, s_c1, s_c2, s_c3, s_c4, s_c5;

    logic               div_start;
    logic signed [31:0] div_num;
    logic               div_done;
    logic signed [31:0] div_q;
    logic               div_sat;

    kf2_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (den[31:0]),
        .o_done  (div_done),
        .o_q     (div_q),
        .o_sat   (div_sat)
    );

    // multiplier operand selection
    always_comb begin
        opa  = r_k1;
        opb  = 33'(r_pp1);
        is_t = 1'b0;
        unique case (r_op)
            OP_X1DT:  begin opa = r_x1;  opb = {17'd0, i_cmd.dt};   is_t = 1'b1; end
            OP_ACCH:  begin opa = i_cmd.acc; opb = {17'd0, i_cmd.hdt2}; is_t = 1'b1; end
            OP_ACCDT: begin opa = i_cmd.acc; opb = {17'd0, i_cmd.dt}; is_t = 1'b1; end
            OP_P3DT:  begin opa = r_p3;  opb = {17'd0, i_cmd.dt};   is_t = 1'b1; end
            OP_P2DT:  begin opa = r_p2;  opb = {17'd0, i_cmd.dt};   is_t = 1'b1; end
            OP_PP1DT: begin opa = r_pp1; opb = {17'd0, i_cmd.dt};   is_t = 1'b1; end
            OP_K0E:   begin opa = r_k0;  opb = 33'(r_e);   end
            OP_K1E:   begin opa = r_k1;  opb = 33'(r_e);   end
            OP_K0P0:  begin opa = r_k0;  opb = 33'(r_pp0); end
            OP_K0P1:  begin opa = r_k0;  opb = 33'(r_pp1); end
            OP_K1P0:  begin opa = r_k1;  opb = 33'(r_pp0); end
            OP_K1P1:  begin opa = r_k1;  opb = 33'(r_pp1); end
            default:  begin opa = r_k1;  opb = 33'(r_pp1); end
        endcase
    end

    // rounding, clipping and the sums fed by the product
    always_comb begin
        mres    = f_sat(f_rnd(r_prod, r_is_t));
        v       = mres.val;
        qn66    = 66'($signed({1'b0, i_qn}));
        den     = 34'($signed({1'b0, i_r})) + 34'(r_pp0);
        den_pos = den > 34'sd0;
        s_xp0   = f_sat(66'(r_x0) + 66'(r_a) + 66'(v));
        s_xp1   = f_sat(66'(r_x1) + 66'(v));
        s_pp1   = f_sat(66'(r_p1) + 66'(v));
        s_pp2   = f_sat(66'(r_p2) + 66'(v));
        s_pp3   = f_sat(66'(r_p3) + qn66);
        s_pp0   = f_sat(66'(r_p0) + qn66 + 66'(r_a) + 66'(v));
        s_e     = f_sat(66'(i_cmd.meas) - 66'(r_xp0));
        s_c0    = f_sat(66'(r_xp0) + 66'(v));
        s_c1    = f_sat(66'(r_xp1) + 66'(v));
        s_c2    = f_sat(66'(r_pp0) - 66'(v));
        s_c3    = f_sat(66'(r_pp1) - 66'(v));
        s_c4    = f_sat(66'(r_pp2) - 66'(v));
        s_c5    = f_sat(66'(r_pp3) - 66'(v));
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            L_IDLE:  if (i_cmd.start) n_st = L_MUL;
            L_MUL:   n_st = L_USE;
            L_USE: begin
                if (r_op == OP_PP1DT) begin
                    n_st = i_cmd.fix ? L_DIVA : L_DONE;
                end else if (r_op == OP_K1P1) begin
                    n_st = L_DONE;
                end else begin
                    n_st = L_MUL;
                end
            end
            L_DIVA:  n_st = den_pos ? L_WAITA : L_MUL;
            L_WAITA: if (div_done) n_st = L_DIVB;
            L_DIVB:  n_st = L_WAITB;
            L_WAITB: if (div_done) n_st = L_MUL;
            L_DONE:  if (i_ack) n_st = L_IDLE;
            default: n_st = L_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        div_start = (r_st == L_DIVA && den_pos) || r_st == L_DIVB;
        div_num   = (r_st == L_DIVB) ? r_pp2 : r_pp0;
        o_res.done = r_st == L_DONE;
        o_res.sat  = r_sat;
        o_res.pos  = r_x0;
        o_res.vel  = r_x1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= L_IDLE;
            r_op <= OP_X1DT;
            r_x0 <= '0;
            r_x1 <= '0;
            r_p0 <= ONE_Q;
            r_p1 <= '0;
            r_p2 <= '0;
            r_p3 <= ONE_Q;
            r_sat <= 1'b0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                L_IDLE: begin
                    if (i_cmd.start) begin
                        r_sat <= 1'b0;
                        r_op  <= OP_X1DT;
                        if (i_cmd.zero_vel) r_x1 <= '0;
                    end
                end
                L_MUL: begin
                    r_prod <= opa * opb;
                    r_is_t <= is_t;
                end
                L_USE: begin
                    r_op <= t_op'(r_op + 4'd1);
                    unique case (r_op)
                        OP_X1DT: begin
                            r_a   <= v;
                            r_sat <= r_sat | mres.hit;
                        end
                        OP_ACCH: begin
                            r_xp0 <= s_xp0.val;
                            r_sat <= r_sat | mres.hit | s_xp0.hit;
                        end
                        OP_ACCDT: begin
                            r_xp1 <= s_xp1.val;
                            r_sat <= r_sat | mres.hit | s_xp1.hit;
                        end
                        OP_P3DT: begin
                            r_pp1 <= s_pp1.val;
                            r_pp2 <= s_pp2.val;
                            r_pp3 <= s_pp3.val;
                            r_sat <= r_sat | mres.hit | s_pp1.hit | s_pp2.hit | s_pp3.hit;
                        end
                        OP_P2DT: begin
                            r_a   <= v;
                            r_sat <= r_sat | mres.hit;
                        end
                        OP_PP1DT: begin
                            r_pp0 <= s_pp0.val;
                            r_sat <= r_sat | mres.hit | s_pp0.hit;
                            if (!i_cmd.fix) begin
                                // no fix: prediction becomes the new state
                                r_x0 <= r_xp0;
                                r_x1 <= r_xp1;
                                r_p0 <= s_pp0.val;
                                r_p1 <= r_pp1;
                                r_p2 <= r_pp2;
                                r_p3 <= r_pp3;
                            end
                        end
                        OP_K0E: begin
                            r_x0  <= s_c0.val;
                            r_sat <= r_sat | mres.hit | s_c0.hit;
                        end
                        OP_K1E: begin
                            r_x1  <= s_c1.val;
                            r_sat <= r_sat | mres.hit | s_c1.hit;
                        end
                        OP_K0P0: begin
                            r_p0  <= s_c2.val;
                            r_sat <= r_sat | mres.hit | s_c2.hit;
                        end
                        OP_K0P1: begin
                            r_p1  <= s_c3.val;
                            r_sat <= r_sat | mres.hit | s_c3.hit;
                        end
                        OP_K1P0: begin
                            r_p2  <= s_c4.val;
                            r_sat <= r_sat | mres.hit | s_c4.hit;
                        end
                        OP_K1P1: begin
                            r_p3  <= s_c5.val;
                            r_sat <= r_sat | mres.hit | s_c5.hit;
                        end
                        default: r_sat <= r_sat;
                    endcase
                end
                L_DIVA: begin
                    r_e   <= s_e.val;
                    r_sat <= r_sat | s_e.hit;
                    r_op  <= OP_K0E;
                    if (!den_pos) begin
                        // non-positive innovation variance: zero gain
                        r_k0 <= '0;
                        r_k1 <= '0;
                    end
                end
                L_WAITA: begin
                    if (div_done) begin
                        r_k0  <= div_q;
                        r_sat <= r_sat | div_sat;
                    end
                end
                L_DIVB: r_op <= OP_K0E;
                L_WAITB: begin
                    if (div_done) begin
                        r_k1  <= div_q;
                        r_sat <= r_sat | div_sat;
                    end
                end
                L_DONE: r_op <= OP_X1DT;
                default: r_op <= OP_X1DT;
            endcase
        end
    end

endmodule
